// ===== rtl/tadc_pkg.sv =====
// Shared constants, resistance table and control types for the thermistor converter.
package tadc_pkg;

  localparam int TABLE_POINTS = 25;
  localparam int AD_BITS      = 12;

  localparam int LAST_PT      = TABLE_POINTS - 1;
  localparam longint AD_FULL  = (longint'(1) << AD_BITS) - 1;
  localparam longint DIV_NUM  = 10000 * AD_FULL * 16;
  localparam int NUM_W        = $clog2(DIV_NUM + 1);
  localparam int R_W          = NUM_W + 1;
  localparam int PT_W         = 21;
  localparam int CNT_W        = $clog2(NUM_W);
  localparam int SEG_W        = $clog2(TABLE_POINTS);
  localparam int Q_BITS       = 7;
  localparam int TEMP_W       = 12;
  localparam int NUM2_W       = PT_W + 8;
  localparam int DV_W         = PT_W + 7;

  localparam int DIVIDER_R16  = 160000;
  localparam int COLD_T16     = -320;
  localparam int STEP_T16     = 80;
  localparam int HOT_T16      = COLD_T16 + STEP_T16 * LAST_PT;

  // Resistance points in ohms times 16, falling with temperature in 5 degree steps.
  function automatic logic [PT_W-1:0] res_pt(input int idx);
    logic [PT_W-1:0] val;
    case (idx)
      0:       val = 21'd1834560;
      1:       val = 21'd1352160;
      2:       val = 21'd1006832;
      3:       val = 21'd753232;
      4:       val = 21'd569008;
      5:       val = 21'd433904;
      6:       val = 21'd333760;
      7:       val = 21'd259264;
      8:       val = 21'd202928;
      9:       val = 21'd160000;
      10:      val = 21'd127072;
      11:      val = 21'd101232;
      12:      val = 21'd81184;
      13:      val = 21'd65648;
      14:      val = 21'd53376;
      15:      val = 21'd43584;
      16:      val = 21'd35792;
      17:      val = 21'd29536;
      18:      val = 21'd24480;
      19:      val = 21'd20400;
      20:      val = 21'd17088;
      21:      val = 21'd14389;
      22:      val = 21'd12171;
      23:      val = 21'd10323;
      24:      val = 21'd8790;
      default: val = '0;
    endcase
    if (idx >= TABLE_POINTS) begin
      val = '0;
    end
    return val;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_CLAMP,
    ST_SEARCH,
    ST_SETUP,
    ST_INTERP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic clamp;
    logic search_step;
    logic interp_start;
    logic interp_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic clamped;
    logic hit;
    logic seg_last;
    logic flat;
    logic interp_last;
  } status_t;

endpackage

// ===== rtl/tadc_dp.sv =====
// Datapath: serial resistance divider, table search and serial interpolation divider.
module tadc_dp import tadc_pkg::*; (
  input  logic                     clk,
  input  logic [11:0]              ad_value,
  input  cmd_t                     cmd,
  output status_t                  status,
  output logic signed [11:0]       temperature
);

  localparam logic [NUM_W-1:0] NUM_BITS = NUM_W'(DIV_NUM);

  logic [AD_BITS-1:0]        ad_q;
  logic [AD_BITS-1:0]        rem;
  logic [NUM_W-1:0]          quo;
  logic [CNT_W-1:0]          cnt;
  logic signed [R_W-1:0]     r16;
  logic [SEG_W-1:0]          seg;
  logic [PT_W-1:0]           d;
  logic [PT_W-1:0]           n;
  logic [NUM2_W-1:0]         num;
  logic [DV_W-1:0]           dv;
  logic [Q_BITS-1:0]         q2;
  logic [TEMP_W-1:0]         res;

  logic [AD_BITS:0]          rem_sh;
  logic                      rem_ge;
  logic signed [R_W-1:0]     r16_calc;
  logic signed [R_W-1:0]     first_s;
  logic signed [R_W-1:0]     last_s;
  logic signed [R_W-1:0]     hi_s;
  logic signed [R_W-1:0]     lo_s;
  logic [PT_W-1:0]           hi_pt;
  logic [PT_W-1:0]           lo_pt;
  logic                      cold;
  logic                      hot;
  logic                      hit;
  logic                      q_bit;
  logic [Q_BITS-1:0]         q2_final;
  int                        base;

  always_comb begin
    rem_sh   = {rem, NUM_BITS[cnt]};
    rem_ge   = rem_sh >= {1'b0, ad_q};
    r16_calc = $signed({1'b0, quo}) - $signed(R_W'(DIVIDER_R16));
    first_s  = $signed({{(R_W-PT_W){1'b0}}, res_pt(0)});
    last_s   = $signed({{(R_W-PT_W){1'b0}}, res_pt(LAST_PT)});
    cold     = (ad_q == '0) || (r16_calc >= first_s);
    hot      = r16_calc <= last_s;
    hi_pt    = res_pt(int'(seg));
    lo_pt    = res_pt(int'(seg) + 1);
    hi_s     = $signed({{(R_W-PT_W){1'b0}}, hi_pt});
    lo_s     = $signed({{(R_W-PT_W){1'b0}}, lo_pt});
    hit      = (r16 <= hi_s) && (r16 >= lo_s);
    q_bit    = num >= {1'b0, dv};
    q2_final = {q2[Q_BITS-2:0], q_bit};
    base     = COLD_T16 + STEP_T16 * int'(seg);

    status.div_last    = cnt == '0;
    status.clamped     = cold || hot;
    status.hit         = hit;
    status.seg_last    = seg == SEG_W'(LAST_PT - 1);
    status.flat        = d == '0;
    status.interp_last = cnt == '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ad_q <= AD_BITS'(ad_value);
      rem  <= '0;
      quo  <= '0;
      cnt  <= CNT_W'(NUM_W - 1);
    end
    if (cmd.div_step) begin
      // One quotient bit per cycle, dividend bits taken MSB first.
      if (rem_ge) begin
        rem <= AD_BITS'(rem_sh - {1'b0, ad_q});
      end else begin
        rem <= rem_sh[AD_BITS-1:0];
      end
      quo <= {quo[NUM_W-2:0], rem_ge};
      cnt <= cnt - 1'b1;
    end
    if (cmd.clamp) begin
      r16 <= r16_calc;
      seg <= '0;
      if (cold) begin
        res <= TEMP_W'(COLD_T16);
      end else if (hot) begin
        res <= TEMP_W'(HOT_T16);
      end
    end
    if (cmd.search_step) begin
      if (hit) begin
        d <= hi_pt - lo_pt;
        n <= PT_W'(hi_s - r16);
      end else if (status.seg_last) begin
        res <= '0;
      end else begin
        seg <= seg + 1'b1;
      end
    end
    if (cmd.interp_start) begin
      if (d == '0) begin
        res <= TEMP_W'(base);
      end
      // 160*n + d, divided below by 2*d with a 7-bit quotient.
      num <= ({8'b0, n} << 7) + ({8'b0, n} << 5) + {8'b0, d};
      dv  <= {d, 7'b0};
      q2  <= '0;
      cnt <= CNT_W'(Q_BITS - 1);
    end
    if (cmd.interp_step) begin
      if (q_bit) begin
        num <= num - {1'b0, dv};
      end
      dv  <= dv >> 1;
      q2  <= q2_final;
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        res <= TEMP_W'(base + int'(q2_final));
      end
    end
    if (cmd.out_load) begin
      temperature <= $signed(res);
    end
  end

endmodule

// ===== rtl/tadc_ctrl.sv =====
// Controller: sequences division, clamping, search and interpolation, and owns the handshakes.
module tadc_ctrl import tadc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    ad_valid,
  output logic    ad_stall,
  output logic    temperature_valid,
  input  logic    temperature_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temperature_valid <= 1'b0;
    end else if (cmd.out_load) begin
      temperature_valid <= 1'b1;
    end else if (!temperature_stall) begin
      temperature_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    ad_stall   = state != ST_IDLE;
    case (state)
      ST_IDLE: begin
        if (ad_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = status.clamped ? ST_FINISH : ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (status.hit) begin
          state_next = ST_SETUP;
        end else if (status.seg_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_SETUP: begin
        cmd.interp_start = 1'b1;
        state_next = status.flat ? ST_FINISH : ST_INTERP;
      end
      ST_INTERP: begin
        cmd.interp_step = 1'b1;
        if (status.interp_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Wait here only while the previous result is still held by the receiver.
        if (!temperature_valid || !temperature_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/thermistor_adc_to_temperature_core.sv =====
// Top level of the thermistor reading to temperature converter.
//
// Input channel: ad_value with ad_valid / ad_stall. An item is taken when
// ad_valid is high and ad_stall is low; ad_stall is high while an item is
// being converted. Output channel: temperature with temperature_valid /
// temperature_stall, one result item per input item, in sixteenths of a
// degree Celsius.
// Each item passes from acceptance to result through the serial divider
// that turns the reading into a resistance, a clamp check, a table search
// (one segment per cycle), serial interpolation division and a load of
// the output register. Clamped readings skip the search and the
// interpolation. Items are converted one at a time: a new item is
// accepted only after the previous one has been loaded into the output
// register.
// The result sits in an output register, so a new item is accepted while
// the receiver stalls; a finished conversion waits until that register is
// free. Reset returns the controller to idle and drops temperature_valid.
module thermistor_adc_to_temperature_core import tadc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [11:0]        ad_value,
  input  logic               ad_valid,
  output logic               ad_stall,
  output logic signed [11:0] temperature,
  output logic               temperature_valid,
  input  logic               temperature_stall
);

  cmd_t    cmd;
  status_t status;

  tadc_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .ad_valid          (ad_valid),
    .ad_stall          (ad_stall),
    .temperature_valid (temperature_valid),
    .temperature_stall (temperature_stall),
    .status            (status),
    .cmd               (cmd)
  );

  tadc_dp u_dp (
    .clk         (clk),
    .ad_value    (ad_value),
    .cmd         (cmd),
    .status      (status),
    .temperature (temperature)
  );

endmodule
